[rtl/core/btok_pkg.sv]
`timescale 1ns / 1ps

package btok_pkg;

  localparam int ARENA_BITS   = 16;
  localparam int COUNTER_BITS = 32;
  localparam int LEN_W        = ARENA_BITS + 1;
  localparam int SUM_W        = LEN_W + 2;

  localparam logic [LEN_W-1:0] ARENA_RESET = LEN_W'(4096);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int OUT_BITS = 8 + 32 + 32 + 1 + LEN_W + 2 + 32 + 32;
  localparam int TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [2:0] KIND_OPEN     = 3'd0;
  localparam logic [2:0] KIND_CLOSE    = 3'd1;
  localparam logic [2:0] KIND_NUMBER   = 3'd2;
  localparam logic [2:0] KIND_STR_CHAR = 3'd3;
  localparam logic [2:0] KIND_STR_END  = 3'd4;
  localparam logic [2:0] KIND_SYM_CHAR = 3'd5;
  localparam logic [2:0] KIND_SYM_END  = 3'd6;
  localparam logic [2:0] KIND_STATUS   = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_MEM  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_END     = 2'd3;

  localparam logic [7:0] CH_OPEN      = 8'h5B;
  localparam logic [7:0] CH_CLOSE     = 8'h5D;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_ZERO      = 8'h30;

  localparam logic [0:0] REG_ARENA_SIZE = 1'b0;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       text_char;
    logic [31:0]      integer_value;
    logic [31:0]      fraction_value;
    logic             minus_sign;
    logic [LEN_W-1:0] text_length;
    logic [1:0]       status;
  } res_t;

  typedef struct packed {
    logic        two;
    res_t [1:0]  res;
    logic [31:0] line_number;
    logic [31:0] column_number;
  } entry_t;

endpackage

[rtl/core/bracket_language_tokenizer.sv]
`timescale 1ns / 1ps
// Channel  Direction  Ports                                     Word
// input    in         s_tvalid s_tready s_tdata s_tlast         one character, tlast = end
// output   out        m_tvalid m_tready m_tdata m_tuser m_tlast one token result
// config   in/out     psel penable pwrite paddr pwdata prdata   arena_size at address 0
//
// One character is taken per cycle unless the queue is full; a character that yields
// two result words fills one queue entry; words leave at one per cycle on m_tready.
// The lexer state update (multiply-by-ten add, arena compare) is combinational.
// A four-entry queue between lexer and output lets each side stall on its own.
// Reset is synchronous and restores arena_size to 4096 and clears all lexer state.

module bracket_language_tokenizer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // char_in
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [btok_pkg::TDATA_W-1:0] m_tdata,   // text_char, integer_value,
                                                  // fraction_value, minus_sign,
                                                  // text_length, status,
                                                  // line_number, column_number
  output logic [2:0]                   m_tuser,   // result_kind
  output logic                         m_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [btok_pkg::LEN_W-1:0] arena_size;
  logic                       queue_full;
  logic                       push;
  btok_pkg::entry_t           push_entry;
  logic                       pop;
  logic                       head_valid;
  btok_pkg::entry_t           head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == btok_pkg::REG_ARENA_SIZE) ? 32'(arena_size) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_size <= btok_pkg::ARENA_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == btok_pkg::REG_ARENA_SIZE) begin
      arena_size <= pwdata[btok_pkg::LEN_W-1:0];
    end
  end

  btok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_char    (s_tdata),
    .in_end     (s_tlast),
    .arena_size (arena_size),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  btok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (head_valid),
    .head       (head)
  );

  btok_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

[rtl/core/btok_front.sv]
`timescale 1ns / 1ps

module btok_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_char,
  input  logic                          in_end,
  input  logic [btok_pkg::LEN_W-1:0]    arena_size,
  input  logic                          queue_full,
  output logic                          push,
  output btok_pkg::entry_t              entry
);

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_INT   = 3'd1;
  localparam logic [2:0] M_FRAC  = 3'd2;
  localparam logic [2:0] M_STR   = 3'd3;
  localparam logic [2:0] M_ESC   = 3'd4;
  localparam logic [2:0] M_AFTER = 3'd5;
  localparam logic [2:0] M_SYM   = 3'd6;

  localparam int LW = btok_pkg::LEN_W;
  localparam int SW = btok_pkg::SUM_W;
  localparam int CW = btok_pkg::COUNTER_BITS;

  logic [2:0]    mode, mode_next;
  logic [31:0]   iacc, iacc_next;
  logic [31:0]   facc, facc_next;
  logic          neg, neg_next;
  logic [LW-1:0] tcount, tcount_next;
  logic [LW-1:0] used, used_next;
  logic [CW-1:0] line, line_next;
  logic [CW-1:0] col, col_next;
  logic          halted, halted_next;
  logic          begun;

  logic             accept;
  logic [7:0]       c;
  logic [1:0]       nres;
  logic             do_begin;
  logic [SW-1:0]    need;
  btok_pkg::res_t   res [2];

  function automatic logic is_digit(logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  endfunction

  function automatic logic [31:0] sat10(logic [31:0] acc, logic [7:0] ch);
    logic [35:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, ch[3:0]};
    return (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic store_fail(logic [LW-1:0] u, logic [LW-1:0] n,
                                      logic [LW-1:0] size);
    return ({2'b00, u} + {2'b00, n} + SW'(1)) >= {2'b00, size};
  endfunction

  function automatic btok_pkg::res_t make_res(logic [2:0] kind, logic [7:0] ch,
                                              logic [1:0] st);
    btok_pkg::res_t r;
    r = '0;
    r.kind = kind;
    r.text_char = ch;
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] low32(logic [CW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  assign in_ready = !queue_full;
  assign accept = in_valid && in_ready;

  always_comb begin
    mode_next   = mode;
    iacc_next   = iacc;
    facc_next   = facc;
    neg_next    = neg;
    tcount_next = tcount;
    used_next   = used;
    line_next   = line;
    col_next    = col;
    halted_next = halted;
    nres        = 2'd0;
    do_begin    = 1'b0;
    need        = {2'b00, used} + {2'b00, tcount} + SW'(1);
    res[0]      = '0;
    res[1]      = '0;
    c           = in_end ? 8'd0 : in_char;

    if (!halted) begin
      if (begun) begin
        if (c == btok_pkg::CH_LF) begin
          line_next = line + CW'(1);
          col_next  = '0;
        end else begin
          col_next = col + CW'(1);
        end
      end

      unique case (mode)
        M_INT: begin
          if (is_digit(c)) begin
            iacc_next = sat10(iacc, c);
          end else if (c == btok_pkg::CH_DOT) begin
            mode_next = M_FRAC;
          end else begin
            res[0] = make_res(btok_pkg::KIND_NUMBER, 8'd0, btok_pkg::ST_OK);
            res[0].integer_value  = iacc;
            res[0].fraction_value = facc;
            res[0].minus_sign     = neg;
            nres = 2'd1;
            mode_next = M_IDLE;
            do_begin = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            facc_next = sat10(facc, c);
          end else begin
            res[0] = make_res(btok_pkg::KIND_NUMBER, 8'd0, btok_pkg::ST_OK);
            res[0].integer_value  = iacc;
            res[0].fraction_value = facc;
            res[0].minus_sign     = neg;
            nres = 2'd1;
            mode_next = M_IDLE;
            do_begin = 1'b1;
          end
        end
        M_STR, M_ESC, M_SYM: begin
          if (mode == M_STR && c == btok_pkg::CH_BACKSLASH) begin
            mode_next = M_ESC;
          end else if (mode == M_STR && c == btok_pkg::CH_QUOTE) begin
            mode_next = M_AFTER;
          end else if ((mode == M_STR && c >= btok_pkg::CH_SPACE && c <= btok_pkg::CH_TILDE)
                       || (mode == M_ESC && (c == btok_pkg::CH_BACKSLASH
                           || c == btok_pkg::CH_QUOTE || c == btok_pkg::CH_N))
                       || (mode == M_SYM && (c == btok_pkg::CH_MINUS || is_alpha(c)
                           || is_digit(c)))) begin
            if (mode == M_ESC) begin
              mode_next = M_STR;
            end
            if (store_fail(used, tcount, arena_size)) begin
              halted_next = 1'b1;
              mode_next = M_IDLE;
              res[0] = make_res(btok_pkg::KIND_STATUS, 8'd0, btok_pkg::ST_NO_MEM);
            end else begin
              tcount_next = tcount + LW'(1);
              res[0] = make_res((mode == M_SYM) ? btok_pkg::KIND_SYM_CHAR
                                                : btok_pkg::KIND_STR_CHAR,
                                (mode == M_ESC && c == btok_pkg::CH_N) ? btok_pkg::CH_LF : c,
                                btok_pkg::ST_OK);
            end
            nres = 2'd1;
          end else if (mode == M_SYM) begin
            if (need > {2'b00, arena_size}) begin
              halted_next = 1'b1;
              mode_next = M_IDLE;
              res[0] = make_res(btok_pkg::KIND_STATUS, 8'd0, btok_pkg::ST_NO_MEM);
            end else begin
              used_next = need[LW-1:0];
              res[0] = make_res(btok_pkg::KIND_SYM_END, 8'd0, btok_pkg::ST_OK);
              res[0].text_length = tcount;
              mode_next = M_IDLE;
              do_begin = 1'b1;
            end
            nres = 2'd1;
          end else begin
            halted_next = 1'b1;
            mode_next = M_IDLE;
            res[0] = make_res(btok_pkg::KIND_STATUS, 8'd0, btok_pkg::ST_INVALID);
            nres = 2'd1;
          end
        end
        M_AFTER: begin
          if (c == btok_pkg::CH_DOT) begin
            halted_next = 1'b1;
            mode_next = M_IDLE;
            res[0] = make_res(btok_pkg::KIND_STATUS, 8'd0, btok_pkg::ST_INVALID);
          end else if (need > {2'b00, arena_size}) begin
            halted_next = 1'b1;
            mode_next = M_IDLE;
            res[0] = make_res(btok_pkg::KIND_STATUS, 8'd0, btok_pkg::ST_NO_MEM);
          end else begin
            used_next = need[LW-1:0];
            res[0] = make_res(btok_pkg::KIND_STR_END, 8'd0, btok_pkg::ST_OK);
            res[0].text_length = tcount;
            mode_next = M_IDLE;
            do_begin = 1'b1;
          end
          nres = 2'd1;
        end
        default: begin
          mode_next = M_IDLE;
          do_begin = 1'b1;
        end
      endcase

      if (do_begin) begin
        if (c == 8'd0) begin
          halted_next = 1'b1;
          mode_next = M_IDLE;
          res[nres[0]] = make_res(btok_pkg::KIND_STATUS, 8'd0, btok_pkg::ST_END);
          nres = nres + 2'd1;
        end else if (c == btok_pkg::CH_SPACE || c == btok_pkg::CH_TAB
                     || c == btok_pkg::CH_LF) begin
          mode_next = M_IDLE;
        end else if (c == btok_pkg::CH_OPEN || c == btok_pkg::CH_CLOSE) begin
          res[nres[0]] = make_res((c == btok_pkg::CH_OPEN) ? btok_pkg::KIND_OPEN
                                                           : btok_pkg::KIND_CLOSE,
                                  8'd0, btok_pkg::ST_OK);
          nres = nres + 2'd1;
        end else if (is_digit(c) || c == btok_pkg::CH_MINUS) begin
          mode_next = M_INT;
          neg_next  = (c == btok_pkg::CH_MINUS);
          iacc_next = is_digit(c) ? {24'd0, c - btok_pkg::CH_ZERO} : 32'd0;
          facc_next = 32'd0;
        end else if (c == btok_pkg::CH_QUOTE) begin
          mode_next = M_STR;
          tcount_next = '0;
        end else if (is_alpha(c)) begin
          tcount_next = '0;
          if (store_fail(used_next, '0, arena_size)) begin
            halted_next = 1'b1;
            mode_next = M_IDLE;
            res[nres[0]] = make_res(btok_pkg::KIND_STATUS, 8'd0, btok_pkg::ST_NO_MEM);
          end else begin
            mode_next = M_SYM;
            tcount_next = LW'(1);
            res[nres[0]] = make_res(btok_pkg::KIND_SYM_CHAR, c, btok_pkg::ST_OK);
          end
          nres = nres + 2'd1;
        end else begin
          halted_next = 1'b1;
          mode_next = M_IDLE;
          res[nres[0]] = make_res(btok_pkg::KIND_STATUS, 8'd0, btok_pkg::ST_INVALID);
          nres = nres + 2'd1;
        end
      end
    end
  end

  assign push = accept && (nres != 2'd0);

  always_comb begin
    entry.two = nres[1];
    entry.res[0] = res[0];
    entry.res[1] = res[1];
    entry.line_number = low32(line_next);
    entry.column_number = low32(col_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      iacc   <= '0;
      facc   <= '0;
      neg    <= 1'b0;
      tcount <= '0;
      used   <= '0;
      line   <= '0;
      col    <= '0;
      halted <= 1'b0;
      begun  <= 1'b0;
    end else if (accept && !halted) begin
      mode   <= mode_next;
      iacc   <= iacc_next;
      facc   <= facc_next;
      neg    <= neg_next;
      tcount <= tcount_next;
      used   <= used_next;
      line   <= line_next;
      col    <= col_next;
      halted <= halted_next;
      begun  <= 1'b1;
    end
  end

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> !push)
    else $error("results produced while halted");

  a_status_halts: assert property (@(posedge clk) disable iff (rst)
    (push && ((!entry.two && entry.res[0].kind == btok_pkg::KIND_STATUS)
              || (entry.two && entry.res[1].kind == btok_pkg::KIND_STATUS)))
    |=> halted)
    else $error("status word did not halt the lexer");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (push && entry.two) |-> (entry.res[0].kind != btok_pkg::KIND_STATUS))
    else $error("status word followed by another word");

endmodule

[rtl/core/btok_queue.sv]
`timescale 1ns / 1ps

module btok_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  btok_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output btok_pkg::entry_t head
);

  localparam int PW = btok_pkg::QPTR_W;

  btok_pkg::entry_t store [btok_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;

  assign full      = (fill == (PW + 1)'(btok_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(btok_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(btok_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW + 1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop)
    else $error("pop from an empty queue");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + (PW + 1)'(1)))
    else $error("queue fill count out of step");

endmodule

[rtl/core/btok_back.sv]
`timescale 1ns / 1ps

module btok_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  btok_pkg::entry_t                head,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [btok_pkg::TDATA_W-1:0]    m_tdata,
  output logic [2:0]                      m_tuser,
  output logic                            m_tlast
);

  logic           sub;
  logic           last;
  btok_pkg::res_t cur;

  assign cur      = head.res[sub];
  assign last     = (sub == head.two);
  assign m_tvalid = head_valid;
  assign m_tlast  = last;
  assign m_tuser  = cur.kind;
  assign m_tdata  = btok_pkg::TDATA_W'({head.column_number, head.line_number, cur.status,
                                        cur.text_length, cur.minus_sign,
                                        cur.fraction_value, cur.integer_value,
                                        cur.text_char});
  assign pop      = head_valid && m_tready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (head_valid && m_tready) begin
      sub <= !last;
    end
  end

  a_sub_needs_pair: assert property (@(posedge clk) disable iff (rst)
    (head_valid && sub) |-> head.two)
    else $error("second word selected from a single-word entry");

  a_pair_in_order: assert property (@(posedge clk) disable iff (rst)
    (head_valid && m_tready && head.two && !sub) |=> sub)
    else $error("second word of a pair skipped");

  a_sub_cleared: assert property (@(posedge clk) disable iff (rst)
    pop |=> !sub)
    else $error("word select not cleared after pop");

endmodule
